@@ src/generation_tagged_slot_pool_assert.svh @@
// assertion macros shared by the slot pool rtl
`ifndef GENERATION_TAGGED_SLOT_POOL_ASSERT_SVH
`define GENERATION_TAGGED_SLOT_POOL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GTSP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtsp assertion failed");

// next-cycle implication, checked outside reset
`define GTSP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtsp assertion failed");

`endif

@@ src/gtsp_pkg.sv @@
// types, codes and sizes shared by the slot pool modules
`default_nettype none

package gtsp_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int GEN_W  = 32;

  localparam logic [SLOT_W-1:0] LAST_SLOT       = SLOT_W'(SLOTS - 1);
  localparam logic [8:0]        SLOTS_LIM       = 9'(SLOTS);
  localparam logic [15:0]       MAX_PAYLOAD_RST = 16'd4096;

  // command codes
  localparam logic [2:0] CMD_PREP_NAMED = 3'd0;
  localparam logic [2:0] CMD_PREP_NEXT  = 3'd1;
  localparam logic [2:0] CMD_CANCEL     = 3'd2;
  localparam logic [2:0] CMD_MARK       = 3'd3;
  localparam logic [2:0] CMD_COMPLETE   = 3'd4;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_SIZE   = 3'd2,
    ST_BUSY   = 3'd3,
    ST_STALE  = 3'd4,
    ST_NOFREE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_FREE     = 2'd0,
    PH_READY    = 2'd1,
    PH_INFLIGHT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  slot_index;
    logic [15:0] payload_length;
    logic [31:0] generation_tag;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  chosen_slot;
    logic [31:0] new_generation;
    logic [8:0]  free_count;
    logic [8:0]  ready_count;
    logic [8:0]  inflight_count;
  } out_t;

  // phase update request toward the slot state
  typedef struct packed {
    logic   we;
    phase_t ph;
    logic   gen_set;
  } upd_t;

  typedef struct packed {
    logic [CNT_W-1:0] free_cnt;
    logic [CNT_W-1:0] ready_cnt;
    logic [CNT_W-1:0] infl_cnt;
  } counts_t;

endpackage

`default_nettype wire

@@ src/gtsp_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none

module gtsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output      logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ src/gtsp_slot_state.sv @@
// per-slot phase flops, generation valid bits and phase counters
`default_nettype none
`include "generation_tagged_slot_pool_assert.svh"

module gtsp_slot_state (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [gtsp_pkg::SLOT_W-1:0]   addr,
  input  wire gtsp_pkg::upd_t                upd,
  output      gtsp_pkg::phase_t              rd_phase,
  output      logic                          rd_gen_valid,
  output      gtsp_pkg::counts_t             cnt
);

  import gtsp_pkg::*;

  phase_t            phase_r [SLOTS];
  logic [SLOTS-1:0]  valid_r;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic [CNT_W-1:0]  ready_r, ready_nxt;
  logic [CNT_W-1:0]  infl_r, infl_nxt;
  logic [9:0]        cnt_sum;
  logic              take_move;

  assign rd_phase     = phase_r[addr];
  assign rd_gen_valid = valid_r[addr];

  // the old phase loses one slot, the new phase gains one
  always_comb begin
    free_nxt  = free_r;
    ready_nxt = ready_r;
    infl_nxt  = infl_r;
    if (upd.we) begin
      case (rd_phase)
        PH_FREE:     free_nxt  = free_r - CNT_W'(1);
        PH_READY:    ready_nxt = ready_r - CNT_W'(1);
        PH_INFLIGHT: infl_nxt  = infl_r - CNT_W'(1);
        default:     free_nxt  = free_r;
      endcase
      case (upd.ph)
        PH_FREE:     free_nxt  = free_r + CNT_W'(1);
        PH_READY:    ready_nxt = ready_r + CNT_W'(1);
        PH_INFLIGHT: infl_nxt  = infl_r + CNT_W'(1);
        default:     free_nxt  = free_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        phase_r[i] <= PH_FREE;
      end
      valid_r <= '0;
      free_r  <= CNT_W'(SLOTS);
      ready_r <= '0;
      infl_r  <= '0;
    end else begin
      if (upd.we) begin
        phase_r[addr] <= upd.ph;
        if (upd.gen_set) begin
          valid_r[addr] <= 1'b1;
        end
      end
      free_r  <= free_nxt;
      ready_r <= ready_nxt;
      infl_r  <= infl_nxt;
    end
  end

  assign cnt.free_cnt  = free_r;
  assign cnt.ready_cnt = ready_r;
  assign cnt.infl_cnt  = infl_r;

  assign cnt_sum   = 10'(free_r) + 10'(ready_r) + 10'(infl_r);
  assign take_move = upd.we && rd_phase == PH_FREE && upd.ph == PH_READY;

  `GTSP_ASSERT_IMP(a_cnt_sum, clk, rst_n, 1'b1, cnt_sum == 10'(SLOTS))
  `GTSP_ASSERT_IMP(a_real_move, clk, rst_n, upd.we, upd.ph != rd_phase)
  `GTSP_ASSERT_IMP(a_gen_set_on_take, clk, rst_n, upd.gen_set, take_move)

endmodule

`default_nettype wire

@@ src/generation_tagged_slot_pool.sv @@
// Slot pool of SLOTS buffer slots, each free, ready or in flight with a 32-bit generation
// tag kept in a small ram. One command is handled at a time: in_ready is high only while
// the sequencer is idle, and the result sits in an output register so the next command is
// taken while a result still waits. A command rejected on range or size passes accept and
// result load only; a named command or a successful search passes accept, generation ram read,
// execute and result load, and a prepare-next first scans slots from the cursor, up to SLOTS,
// because phases are examined one slot a cycle through a single read port. Generation tags
// never written read as zero through per-slot valid bits, so no clearing pass is needed after
// reset. max_payload may only be written while idle.
`default_nettype none
`include "generation_tagged_slot_pool_assert.svh"

module generation_tagged_slot_pool (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire gtsp_pkg::in_t   in_data,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      gtsp_pkg::out_t  out_data,
  input  wire logic            cfg_we,
  input  wire logic [15:0]     cfg_wdata
);

  import gtsp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_READ = 5'b00100,
    S_EXEC = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [2:0]          cmd_r, cmd_nxt;
  logic [31:0]         tag_r, tag_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic [SLOT_W-1:0]   cursor_r, cursor_nxt;
  status_t             status_r, status_nxt;
  logic [7:0]          chosen_r, chosen_nxt;
  logic [31:0]         newgen_r, newgen_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_r, out_nxt;
  logic [15:0]         max_payload_r;

  logic                in_fire;
  logic                size_ok;
  logic                idx_ok;
  logic [SLOT_W-1:0]   slot_inc;
  logic                ram_re, ram_we;
  logic [GEN_W-1:0]    ram_q, ram_wdata;
  logic [GEN_W-1:0]    gen_cur, gen_inc, gen_bump;
  phase_t              rd_phase, need_phase;
  logic                rd_gen_valid;
  upd_t                upd;
  counts_t             cnt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign size_ok  = (in_data.payload_length != 16'd0) &&
                    (in_data.payload_length <= max_payload_r);
  assign idx_ok   = ({1'b0, in_data.slot_index} < SLOTS_LIM);
  assign slot_inc = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);

  // shared generation unit: bump skipping zero, compare against the tag
  assign gen_cur    = rd_gen_valid ? ram_q : '0;
  assign gen_inc    = gen_cur + GEN_W'(1);
  assign gen_bump   = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
  assign need_phase = (cmd_r == CMD_COMPLETE) ? PH_INFLIGHT : PH_READY;
  assign ram_wdata  = gen_bump;

  gtsp_ram #(
    .WIDTH(GEN_W),
    .DEPTH(SLOTS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_r),
    .rdata (ram_q)
  );

  gtsp_slot_state u_slot_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .addr         (slot_r),
    .upd          (upd),
    .rd_phase     (rd_phase),
    .rd_gen_valid (rd_gen_valid),
    .cnt          (cnt)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    tag_nxt       = tag_r;
    slot_nxt      = slot_r;
    scan_cnt_nxt  = scan_cnt_r;
    cursor_nxt    = cursor_r;
    status_nxt    = status_r;
    chosen_nxt    = chosen_r;
    newgen_nxt    = newgen_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    upd           = '{we: 1'b0, ph: PH_FREE, gen_set: 1'b0};

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt      = in_data.cmd;
          tag_nxt      = in_data.generation_tag;
          slot_nxt     = in_data.slot_index[SLOT_W-1:0];
          scan_cnt_nxt = '0;
          status_nxt   = ST_OK;
          newgen_nxt   = '0;
          chosen_nxt   = in_data.slot_index;
          case (in_data.cmd)
            CMD_PREP_NAMED: begin
              if (!idx_ok) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESP;
              end else if (!size_ok) begin
                status_nxt = ST_SIZE;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_READ;
              end
            end
            CMD_PREP_NEXT: begin
              chosen_nxt = '0;
              slot_nxt   = cursor_r;
              if (!size_ok) begin
                status_nxt = ST_SIZE;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_CANCEL, CMD_MARK, CMD_COMPLETE: begin
              if (!idx_ok) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
              status_nxt = ST_RANGE;
              state_nxt  = S_RESP;
            end
          endcase
        end
      end

      // one candidate a beat, round robin from the cursor
      S_SCAN: begin
        if (rd_phase == PH_FREE) begin
          state_nxt = S_READ;
        end else if (scan_cnt_r == LAST_SLOT) begin
          status_nxt = ST_NOFREE;
          state_nxt  = S_RESP;
        end else begin
          slot_nxt     = slot_inc;
          scan_cnt_nxt = scan_cnt_r + SLOT_W'(1);
        end
      end

      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        state_nxt = S_RESP;
        if (cmd_r == CMD_PREP_NAMED || cmd_r == CMD_PREP_NEXT) begin
          if (rd_phase != PH_FREE) begin
            status_nxt = ST_BUSY;
          end else begin
            ram_we     = 1'b1;
            upd        = '{we: 1'b1, ph: PH_READY, gen_set: 1'b1};
            newgen_nxt = gen_bump;
            if (cmd_r == CMD_PREP_NEXT) begin
              chosen_nxt = 8'(slot_r);
              cursor_nxt = slot_inc;
            end
          end
        end else begin
          if (rd_phase != need_phase || gen_cur != tag_r) begin
            status_nxt = ST_STALE;
          end else begin
            upd.we = 1'b1;
            upd.ph = (cmd_r == CMD_MARK) ? PH_INFLIGHT : PH_FREE;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.status         = status_r;
          out_nxt.chosen_slot    = chosen_r;
          out_nxt.new_generation = newgen_r;
          out_nxt.free_count     = 9'(cnt.free_cnt);
          out_nxt.ready_count    = 9'(cnt.ready_cnt);
          out_nxt.inflight_count = 9'(cnt.infl_cnt);
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cursor_r      <= '0;
      out_valid_r   <= 1'b0;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_payload_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    tag_r      <= tag_nxt;
    slot_r     <= slot_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    status_r   <= status_nxt;
    chosen_r   <= chosen_nxt;
    newgen_r   <= newgen_nxt;
    out_r      <= out_nxt;
  end

  `GTSP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready)
  `GTSP_ASSERT_IMP(a_gen_nonzero, clk, rst_n, ram_we, ram_wdata != '0)
  `GTSP_ASSERT_NXT(a_exec_then_resp, clk, rst_n, state_r == S_EXEC, state_r == S_RESP)

endmodule

`default_nettype wire
